### src/array_list_insert_delete_unit_macros.svh
// Assertion macros shared by the array list insert/delete unit.
`ifndef ARRAY_LIST_INSERT_DELETE_UNIT_MACROS_SVH
`define ARRAY_LIST_INSERT_DELETE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked assertion that is switched off while reset is held.
`define ALID_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that is checked on every edge, reset included.
`define ALID_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ALID_ASSERT_RST(label, prop, msg)
`define ALID_ASSERT_ALL(label, prop, msg)
`endif

`endif

### src/alid_pkg.sv
// Package with types and constants of the array list insert/delete unit.
package alid_pkg;

  localparam int DEPTH_DEF   = 128;
  localparam int DATA_W      = 32;
  localparam int POS_W       = 8;
  localparam int KIND_W      = 2;
  localparam int CNT_OUT_W   = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_FILL,
    S_SHIFT_DN,
    S_READ
  } state_t;

endpackage

### src/array_list_insert_delete_unit.sv
// Top level of the array list unit: ordered list of signed words with insert, append, delete, read.
//
// The unit keeps an ordered list of up to DEPTH signed 32-bit words in one
// memory, packed from index 0, with an entry count held in a register. A
// transaction is accepted at a rising edge where start is high and busy is
// low. Each transaction yields exactly one result, shown for one cycle with
// out_valid high; the receiver cannot stall, so it must take the result in
// that cycle. Append, an insert at the end of the list, any rejected
// transaction, and a delete of the last entry return their result in the
// cycle after acceptance and leave busy low, so a new transaction may start
// at once. A read keeps busy high in the S_READ state and returns its result
// from the registered memory read port through the result register. An
// insert at a position p below the count moves the entries from p upward one
// word per cycle and then writes the new word. A delete at position p moves
// the later entries down one word per cycle. The single memory read port and
// single write port set this pace, so the longest transaction is an insert
// at the front of a list that holds DEPTH - 1 entries. A rejected
// transaction (status position out of range or list full) leaves the list
// unchanged. The entry count output shows the low 8 bits of the count; the
// empty and full flags are always exact.
`include "array_list_insert_delete_unit_macros.svh"

module array_list_insert_delete_unit
  import alid_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [KIND_W-1:0]           in_kind,
  input  logic [POS_W-1:0]            in_position,
  input  logic signed [DATA_W-1:0]    in_value,
  output logic                        out_valid,
  output logic signed [DATA_W-1:0]    out_read_value,
  output logic [1:0]                  out_status,
  output logic [CNT_OUT_W-1:0]        out_entry_count,
  output logic                        out_empty_flag,
  output logic                        out_full_flag
);

  // Address and count widths follow from DEPTH; the compare width is the larger of the count width and POS_W.
  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CmpW = (CW > POS_W) ? CW : POS_W;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic signed [DATA_W-1:0] word_r, word_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  status_r, status_nxt;
  logic signed [DATA_W-1:0] rd_r, rd_nxt;

  // Memory port controls.
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  logic [CmpW-1:0]          pos_ext;
  logic [CmpW-1:0]          cnt_ext;
  logic [AW-1:0]            in_pos_a;
  logic [AW-1:0]            cnt_m1;
  logic                     list_full;
  logic                     list_empty;

  alid_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Position and count compared at a common width, so that any DEPTH works.
  assign pos_ext    = CmpW'(in_position);
  assign cnt_ext    = CmpW'(count_r);
  assign in_pos_a   = AW'(in_position);
  assign cnt_m1     = AW'(count_r - CW'(1));
  assign list_full  = (count_r == CW'(DEPTH));
  assign list_empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    word_r   <= word_nxt;
    status_r <= status_nxt;
    rd_r     <= rd_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    word_nxt      = word_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    rd_nxt        = rd_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = idx_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          // Every transaction that finishes here reports in the next cycle.
          out_valid_nxt = 1'b1;
          status_nxt    = ST_DONE;
          rd_nxt        = '0;
          case (kind_t'(in_kind))
            KIND_INSERT: begin
              if (list_full) begin
                status_nxt = ST_FULL;
              end else if (pos_ext > cnt_ext) begin
                status_nxt = ST_RANGE;
              end else if (pos_ext == cnt_ext) begin
                // Inserting at the end needs no shift.
                mem_we    = 1'b1;
                mem_waddr = AW'(count_r);
                mem_wdata = in_value;
                count_nxt = count_r + CW'(1);
              end else begin
                // Start moving entries up from the top of the list.
                out_valid_nxt = 1'b0;
                mem_re        = 1'b1;
                mem_raddr     = cnt_m1;
                idx_nxt       = cnt_m1;
                pos_nxt       = in_pos_a;
                word_nxt      = in_value;
                state_nxt     = S_SHIFT_UP;
              end
            end
            KIND_APPEND: begin
              if (list_full) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(count_r);
                mem_wdata = in_value;
                count_nxt = count_r + CW'(1);
              end
            end
            KIND_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                status_nxt = ST_RANGE;
              end else if (pos_ext == cnt_ext - CmpW'(1)) begin
                // Dropping the last entry only shortens the list.
                count_nxt = count_r - CW'(1);
              end else begin
                out_valid_nxt = 1'b0;
                mem_re        = 1'b1;
                mem_raddr     = in_pos_a + AW'(1);
                idx_nxt       = in_pos_a + AW'(1);
                state_nxt     = S_SHIFT_DN;
              end
            end
            KIND_READ: begin
              if (pos_ext >= cnt_ext) begin
                status_nxt = ST_RANGE;
              end else begin
                out_valid_nxt = 1'b0;
                mem_re        = 1'b1;
                mem_raddr     = in_pos_a;
                state_nxt     = S_READ;
              end
            end
            default: begin
              status_nxt = ST_RANGE;
            end
          endcase
        end
      end

      S_SHIFT_UP: begin
        // The word read last cycle from idx_r moves one place up.
        mem_we    = 1'b1;
        mem_waddr = idx_r + AW'(1);
        mem_wdata = mem_rdata;
        if (idx_r == pos_r) begin
          state_nxt = S_FILL;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r - AW'(1);
          idx_nxt   = idx_r - AW'(1);
        end
      end

      S_FILL: begin
        mem_we        = 1'b1;
        mem_waddr     = pos_r;
        mem_wdata     = word_r;
        count_nxt     = count_r + CW'(1);
        out_valid_nxt = 1'b1;
        status_nxt    = ST_DONE;
        rd_nxt        = '0;
        state_nxt     = S_IDLE;
      end

      S_SHIFT_DN: begin
        // The word read last cycle from idx_r moves one place down.
        mem_we    = 1'b1;
        mem_waddr = idx_r - AW'(1);
        mem_wdata = mem_rdata;
        if (CW'(idx_r) == count_r - CW'(1)) begin
          count_nxt     = count_r - CW'(1);
          out_valid_nxt = 1'b1;
          status_nxt    = ST_DONE;
          rd_nxt        = '0;
          state_nxt     = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r + AW'(1);
          idx_nxt   = idx_r + AW'(1);
        end
      end

      S_READ: begin
        out_valid_nxt = 1'b1;
        status_nxt    = ST_DONE;
        rd_nxt        = mem_rdata;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The count only changes at the edge that also raises out_valid, so the
  // count and flags read straight from the register during the result cycle.
  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_read_value  = rd_r;
  assign out_status      = status_r;
  assign out_entry_count = cnt_ext[CNT_OUT_W-1:0];
  assign out_empty_flag  = list_empty;
  assign out_full_flag   = list_full;

  `ALID_ASSERT_RST(a_count_bound, count_r <= CW'(DEPTH), "entry count exceeds DEPTH")
  `ALID_ASSERT_RST(a_result_idle, out_valid_r |-> state_r == S_IDLE, "result while sequencer busy")
  `ALID_ASSERT_RST(a_err_keeps_count, (out_valid_r && status_r != ST_DONE) |-> count_r == $past(count_r), "rejected transaction changed the count")
  `ALID_ASSERT_RST(a_shift_in_list, (state_r == S_SHIFT_UP || state_r == S_SHIFT_DN) |-> CW'(idx_r) < count_r, "shift address outside the list")
  `ALID_ASSERT_ALL(a_reset_clears, !rst_n |=> (!out_valid_r && state_r == S_IDLE), "reset did not clear control state")

endmodule

### src/alid_ram.sv
// Simple dual-port word memory with one write port and one registered read port.
module alid_ram
  import alid_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AddrW-1:0]         waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic                     re,
  input  logic [AddrW-1:0]         raddr,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
